>>> hdl/assert_macros.svh
// Assertion macros shared by the tween engine RTL.
// Needs nothing else; each file that checks itself includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/ets_pkg.sv
// Shared types and constants of the tween slot engine.
// Used by ets_ctrl, ets_dpath and easing_tween_slot_engine.
package ets_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int VALUE_W = 32;
  localparam int TIME_W  = 26;
  localparam int EL_W    = 27;
  localparam int CURVE_W = 4;
  localparam int SF_W    = 16;
  localparam int EPS_W   = 16;

  localparam logic [16:0]     P_ONE     = 17'h10000;
  localparam logic [EL_W-1:0] EL_MAX    = 27'h7FFFFFF;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

  // Opcodes
  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_TICK   = 3'd0;
  localparam opcode_t OP_START  = 3'd1;
  localparam opcode_t OP_CANCEL = 3'd2;
  localparam opcode_t OP_QUERY  = 3'd3;
  localparam opcode_t OP_SET    = 3'd4;
  localparam opcode_t OP_CLEAR  = 3'd5;

  // Curve codes
  typedef logic [CURVE_W-1:0] curve_t;
  localparam curve_t CRV_LINEAR     = 4'd0;
  localparam curve_t CRV_SMOOTH_END = 4'd1;
  localparam curve_t CRV_QUAD_INOUT = 4'd2;
  localparam curve_t CRV_QUAD_IN    = 4'd3;
  localparam curve_t CRV_QUAD_OUT   = 4'd4;
  localparam curve_t CRV_CUBIC_IN   = 4'd5;
  localparam curve_t CRV_CUBIC_OUT  = 4'd6;
  localparam curve_t CRV_QUART_IN   = 4'd7;
  localparam curve_t CRV_QUART_OUT  = 4'd8;

  // Datapath commands, one per cycle
  typedef enum logic [5:0] {
    C_NOP, C_LATCH, C_EXEC, C_REPORT, C_EMPTY, C_NEXT,
    C_DLY, C_EPS, C_DIVI, C_DIV, C_LIN, C_EINIT,
    C_PM1, C_PS1, C_PM2, C_PS2, C_EFIN,
    C_SINIT, C_SMA, C_SSA, C_SMQ, C_SSQ,
    C_QI, C_QS, C_QW, C_FM, C_FS, C_KDEC, C_SFIN,
    C_LMUL, C_LST, C_EMIT
  } dp_cmd_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_REPORT, ST_TSTART, ST_CHK, ST_DLY, ST_EPS,
    ST_DIVI, ST_DIV, ST_ESEL, ST_EINIT, ST_PM1, ST_PS1, ST_PM2, ST_PS2,
    ST_EFIN, ST_SINIT, ST_SMA, ST_SSA, ST_SMQ, ST_SSQ, ST_QI, ST_QS,
    ST_QW, ST_FM, ST_FS, ST_FNEXT, ST_SFIN, ST_LMUL, ST_LST, ST_EMIT
  } state_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic any_act;
    logic slot_act;
    logic started;
    logic dly_done;
    logic eps_done;
    logic div_last;
    logic ease_lin;
    logic ease_smooth;
    logic ease_two;
    logic int_bit;
    logic int_last;
    logic isq_last;
    logic frac_bit;
    logic k_zero;
    logic slot_last;
  } dp_status_t;

  // Integer part of a Q16.16 value, truncated toward zero
  function automatic logic [16:0] trunc_int(input logic [31:0] v);
    logic [32:0] mag;
    logic [16:0] q;
    mag = v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
    q   = mag[32:16];
    return v[31] ? (17'd0 - q) : q;
  endfunction

endpackage

>>> hdl/ets_ctrl.sv
// Sequencer of the tween slot engine: walks items, slots and easing steps.
// Depends on ets_pkg and assert_macros.svh; drives ets_dpath by commands.
`include "assert_macros.svh"

module ets_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ets_pkg::opcode_t     opcode,
  input  ets_pkg::dp_status_t  st,
  output ets_pkg::dp_cmd_t     cmd,
  output logic                 busy
);

  ets_pkg::state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ets_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ets_pkg::ST_IDLE);

  // Choose next state and command
  always_comb begin
    state_next = state;
    cmd        = ets_pkg::C_NOP;
    case (state)
      ets_pkg::ST_IDLE: begin
        if (start) begin
          cmd = ets_pkg::C_LATCH;
          state_next = (opcode == ets_pkg::OP_TICK) ? ets_pkg::ST_TSTART : ets_pkg::ST_EXEC;
        end
      end
      ets_pkg::ST_EXEC: begin
        cmd = ets_pkg::C_EXEC;
        state_next = ets_pkg::ST_REPORT;
      end
      ets_pkg::ST_REPORT: begin
        cmd = ets_pkg::C_REPORT;
        state_next = ets_pkg::ST_IDLE;
      end
      ets_pkg::ST_TSTART: begin
        if (!st.any_act) begin
          cmd = ets_pkg::C_EMPTY;
          state_next = ets_pkg::ST_IDLE;
        end else begin
          state_next = ets_pkg::ST_CHK;
        end
      end
      ets_pkg::ST_CHK: begin
        if (st.slot_act) begin
          state_next = ets_pkg::ST_DLY;
        end else begin
          cmd = ets_pkg::C_NEXT;
        end
      end
      ets_pkg::ST_DLY: begin
        cmd = ets_pkg::C_DLY;
        state_next = (!st.started && !st.dly_done) ? ets_pkg::ST_EMIT : ets_pkg::ST_EPS;
      end
      ets_pkg::ST_EPS: begin
        cmd = ets_pkg::C_EPS;
        state_next = st.eps_done ? ets_pkg::ST_EMIT : ets_pkg::ST_DIVI;
      end
      ets_pkg::ST_DIVI: begin
        cmd = ets_pkg::C_DIVI;
        state_next = ets_pkg::ST_DIV;
      end
      ets_pkg::ST_DIV: begin
        cmd = ets_pkg::C_DIV;
        if (st.div_last) state_next = ets_pkg::ST_ESEL;
      end
      ets_pkg::ST_ESEL: begin
        if (st.ease_lin) begin
          cmd = ets_pkg::C_LIN;
          state_next = ets_pkg::ST_LMUL;
        end else if (st.ease_smooth) begin
          state_next = ets_pkg::ST_SINIT;
        end else begin
          state_next = ets_pkg::ST_EINIT;
        end
      end
      ets_pkg::ST_EINIT: begin
        cmd = ets_pkg::C_EINIT;
        state_next = ets_pkg::ST_PM1;
      end
      ets_pkg::ST_PM1: begin
        cmd = ets_pkg::C_PM1;
        state_next = ets_pkg::ST_PS1;
      end
      ets_pkg::ST_PS1: begin
        cmd = ets_pkg::C_PS1;
        state_next = st.ease_two ? ets_pkg::ST_PM2 : ets_pkg::ST_EFIN;
      end
      ets_pkg::ST_PM2: begin
        cmd = ets_pkg::C_PM2;
        state_next = ets_pkg::ST_PS2;
      end
      ets_pkg::ST_PS2: begin
        cmd = ets_pkg::C_PS2;
        state_next = ets_pkg::ST_EFIN;
      end
      ets_pkg::ST_EFIN: begin
        cmd = ets_pkg::C_EFIN;
        state_next = ets_pkg::ST_LMUL;
      end
      ets_pkg::ST_SINIT: begin
        cmd = ets_pkg::C_SINIT;
        state_next = ets_pkg::ST_SMA;
      end
      ets_pkg::ST_SMA: begin
        if (st.int_bit) begin
          cmd = ets_pkg::C_SMA;
          state_next = ets_pkg::ST_SSA;
        end else begin
          state_next = ets_pkg::ST_SMQ;
        end
      end
      ets_pkg::ST_SSA: begin
        cmd = ets_pkg::C_SSA;
        state_next = ets_pkg::ST_SMQ;
      end
      ets_pkg::ST_SMQ: begin
        cmd = ets_pkg::C_SMQ;
        state_next = ets_pkg::ST_SSQ;
      end
      ets_pkg::ST_SSQ: begin
        cmd = ets_pkg::C_SSQ;
        state_next = st.int_last ? ets_pkg::ST_QI : ets_pkg::ST_SMA;
      end
      ets_pkg::ST_QI: begin
        cmd = ets_pkg::C_QI;
        state_next = ets_pkg::ST_QS;
      end
      ets_pkg::ST_QS: begin
        cmd = ets_pkg::C_QS;
        if (st.isq_last) state_next = ets_pkg::ST_QW;
      end
      ets_pkg::ST_QW: begin
        cmd = ets_pkg::C_QW;
        state_next = ets_pkg::ST_FNEXT;
        if (st.frac_bit) state_next = ets_pkg::ST_FM;
      end
      ets_pkg::ST_FM: begin
        cmd = ets_pkg::C_FM;
        state_next = ets_pkg::ST_FS;
      end
      ets_pkg::ST_FS: begin
        cmd = ets_pkg::C_FS;
        state_next = ets_pkg::ST_FNEXT;
      end
      ets_pkg::ST_FNEXT: begin
        if (st.k_zero) begin
          state_next = ets_pkg::ST_SFIN;
        end else begin
          cmd = ets_pkg::C_KDEC;
          state_next = ets_pkg::ST_QI;
        end
      end
      ets_pkg::ST_SFIN: begin
        cmd = ets_pkg::C_SFIN;
        state_next = ets_pkg::ST_LMUL;
      end
      ets_pkg::ST_LMUL: begin
        cmd = ets_pkg::C_LMUL;
        state_next = ets_pkg::ST_LST;
      end
      ets_pkg::ST_LST: begin
        cmd = ets_pkg::C_LST;
        state_next = ets_pkg::ST_EMIT;
      end
      ets_pkg::ST_EMIT: begin
        cmd = ets_pkg::C_EMIT;
        state_next = st.slot_last ? ets_pkg::ST_IDLE : ets_pkg::ST_CHK;
      end
      default: begin
        state_next = ets_pkg::ST_IDLE;
      end
    endcase
  end

  // An empty tick report only when no slot holds an animation
  `ASSERT_IMPLIES(a_empty_none, clk, rst, cmd == ets_pkg::C_EMPTY, !st.any_act)

endmodule

>>> hdl/ets_dpath.sv
// Datapath of the tween slot engine: slot state, divider, multiplier,
// square-root unit and result registers. Depends on ets_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ets_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  ets_pkg::dp_cmd_t                    cmd,
  output ets_pkg::dp_status_t                 st,
  input  ets_pkg::opcode_t                    opcode,
  input  logic [ets_pkg::SLOT_W-1:0]          slot,
  input  logic signed [ets_pkg::VALUE_W-1:0]  value,
  input  logic [ets_pkg::TIME_W-1:0]          duration_us,
  input  logic [ets_pkg::TIME_W-1:0]          delay_us,
  input  logic [ets_pkg::TIME_W-1:0]          frame_us,
  input  logic [ets_pkg::CURVE_W-1:0]         curve,
  input  logic [ets_pkg::SF_W-1:0]            smooth_factor,
  input  logic                                cfg_we,
  input  logic [ets_pkg::EPS_W-1:0]           cfg_wdata,
  output logic                                valid,
  output logic [ets_pkg::SLOT_W-1:0]          out_slot,
  output logic signed [ets_pkg::VALUE_W-1:0]  out_value,
  output logic                                finished,
  output logic                                active,
  output logic [ets_pkg::EL_W-1:0]            remaining_us,
  output logic                                last
);

  localparam int NS = ets_pkg::SLOTS;

  // Latched item
  ets_pkg::opcode_t                op_r;
  logic [ets_pkg::SLOT_W-1:0]      idx;
  logic [31:0]                     value_r;
  logic [ets_pkg::TIME_W-1:0]      dur_r, dly_r, frame_r;
  logic [ets_pkg::CURVE_W-1:0]     curve_r;
  logic [ets_pkg::SF_W-1:0]        sf_r;
  logic [ets_pkg::EPS_W-1:0]       eps;

  // Slot state
  logic [31:0]                 cur   [NS];
  logic [31:0]                 tgt   [NS];
  logic [31:0]                 stv   [NS];
  logic [ets_pkg::TIME_W-1:0]  dur_a [NS];
  logic [ets_pkg::TIME_W-1:0]  dly_a [NS];
  logic [ets_pkg::EL_W-1:0]    el_a  [NS];
  logic [ets_pkg::CURVE_W-1:0] crv_a [NS];
  logic [ets_pkg::SF_W-1:0]    sexp_a[NS];
  logic [NS-1:0]               act, started;

  // Work registers
  logic               fin;
  logic [16:0]        p, pe, t;
  logic [17:0]        base, opb;
  logic               sh17, hi2;
  logic [25:0]        rem;
  logic [3:0]         dcnt;
  logic [30:0]        acc, sq, s;
  logic [2:0]         ibit, k;
  logic [61:0]        qx, qr;
  logic [4:0]         bcnt;
  logic signed [65:0] mres;

  // Selected slot
  logic [31:0]                 cur_i, tgt_i, stv_i;
  logic [ets_pkg::TIME_W-1:0]  dur_i, dly_i;
  logic [ets_pkg::EL_W-1:0]    el_i;
  logic [ets_pkg::CURVE_W-1:0] crv_i;
  logic [ets_pkg::SF_W-1:0]    sexp_i;

  assign cur_i  = cur[idx];
  assign tgt_i  = tgt[idx];
  assign stv_i  = stv[idx];
  assign dur_i  = dur_a[idx];
  assign dly_i  = dly_a[idx];
  assign el_i   = el_a[idx];
  assign crv_i  = crv_a[idx];
  assign sexp_i = sexp_a[idx];

  // Saturating elapsed time
  logic [ets_pkg::EL_W:0]   el_sum;
  logic [ets_pkg::EL_W-1:0] el_add;
  assign el_sum = {1'b0, el_i} + {2'b0, frame_r};
  assign el_add = (el_sum > {1'b0, ets_pkg::EL_MAX}) ? ets_pkg::EL_MAX
                                                      : el_sum[ets_pkg::EL_W-1:0];

  // Epsilon closeness and full time
  logic signed [32:0] c33, t33;
  logic [32:0]        diff;
  logic [31:0]        abs_c, abs_t, amax;
  logic [15:0]        thr;
  logic               eps_hit, time_up;
  always_comb begin
    c33   = {cur_i[31], cur_i};
    t33   = {tgt_i[31], tgt_i};
    diff  = (c33 > t33) ? 33'(c33 - t33) : 33'(t33 - c33);
    abs_c = cur_i[31] ? (32'd0 - cur_i) : cur_i;
    abs_t = tgt_i[31] ? (32'd0 - tgt_i) : tgt_i;
    amax  = (abs_t > abs_c) ? abs_t : abs_c;
    thr   = (eps > {4'b0, amax[31:20]}) ? eps : {4'b0, amax[31:20]};
    eps_hit = (diff <= {17'b0, thr});
    time_up = (el_i >= {1'b0, dur_i});
  end

  // Restoring divider step
  logic [26:0] r2;
  logic        dge;
  assign r2  = {rem, 1'b0};
  assign dge = (r2 >= {1'b0, dur_i});

  // Square-root step
  logic [61:0] qb, qsum;
  logic        qge;
  assign qb   = 62'd1 << {bcnt, 1'b0};
  assign qsum = qr + qb;
  assign qge  = (qx >= qsum);

  // Easing operand setup
  logic [16:0] x2, omp;
  logic [17:0] ei_base, ei_opb;
  logic        ei_sh17, ei_hi2;
  always_comb begin
    x2      = {p[15:0], 1'b0};
    omp     = ets_pkg::P_ONE - p;
    ei_base = {1'b0, p};
    ei_opb  = {1'b0, p};
    ei_sh17 = 1'b0;
    ei_hi2  = 1'b0;
    case (crv_i)
      ets_pkg::CRV_QUAD_INOUT: begin
        if (x2 < ets_pkg::P_ONE) begin
          ei_base = {1'b0, x2};
          ei_opb  = {1'b0, x2};
          ei_sh17 = 1'b1;
        end else begin
          ei_base = {1'b0, x2 - ets_pkg::P_ONE};
          ei_opb  = 18'h20000 - {1'b0, x2 - ets_pkg::P_ONE};
          ei_hi2  = 1'b1;
        end
      end
      ets_pkg::CRV_QUAD_OUT: begin
        ei_opb = 18'h20000 - {1'b0, p};
      end
      ets_pkg::CRV_CUBIC_OUT, ets_pkg::CRV_QUART_OUT: begin
        ei_base = {1'b0, omp};
        ei_opb  = {1'b0, omp};
      end
      default: begin
        ei_base = {1'b0, p};
      end
    endcase
  end

  logic quart;
  assign quart = (crv_i == ets_pkg::CRV_QUART_IN) || (crv_i == ets_pkg::CRV_QUART_OUT);

  // Final easing value
  logic [17:0] half_sum;
  logic [16:0] efin;
  always_comb begin
    half_sum = {1'b0, ets_pkg::P_ONE} + {1'b0, t};
    case (crv_i)
      ets_pkg::CRV_CUBIC_OUT, ets_pkg::CRV_QUART_OUT: efin = ets_pkg::P_ONE - t;
      ets_pkg::CRV_QUAD_INOUT: efin = hi2 ? half_sum[17:1] : t;
      default: efin = t;
    endcase
  end

  // Multiplier operands
  logic signed [32:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd)
      ets_pkg::C_PM1: begin
        ma = {15'b0, base};
        mb = {15'b0, opb};
      end
      ets_pkg::C_PM2: begin
        ma = {16'b0, t};
        mb = quart ? {16'b0, t} : {15'b0, base};
      end
      ets_pkg::C_SMA: begin
        ma = {2'b0, acc};
        mb = {2'b0, sq};
      end
      ets_pkg::C_SMQ: begin
        ma = {2'b0, sq};
        mb = {2'b0, sq};
      end
      ets_pkg::C_FM: begin
        ma = {2'b0, acc};
        mb = {2'b0, s};
      end
      ets_pkg::C_LMUL: begin
        ma = t33 - {stv_i[31], stv_i};
        mb = {16'b0, pe};
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  // Interpolation and integer-part snap
  logic [31:0] lerp_v;
  logic        snap;
  assign lerp_v = stv_i + mres[47:16];
  assign snap   = (crv_i == ets_pkg::CRV_SMOOTH_END) &&
                  (ets_pkg::trunc_int(lerp_v) == ets_pkg::trunc_int(tgt_i));

  // Remaining time of the selected slot
  logic [ets_pkg::EL_W-1:0] rem_us, dly_left;
  always_comb begin
    dly_left = (dly_i > el_i[ets_pkg::TIME_W-1:0] && !el_i[ets_pkg::EL_W-1])
               ? {1'b0, dly_i} - el_i : '0;
    if (!act[idx]) begin
      rem_us = '0;
    end else if (!started[idx]) begin
      rem_us = dly_left + {1'b0, dur_i};
    end else begin
      rem_us = ({1'b0, dur_i} > el_i) ? ({1'b0, dur_i} - el_i) : '0;
    end
  end

  // Mask of the slots above the selected one
  logic [NS-1:0] above;
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      above[j] = ((ets_pkg::SLOT_W+1)'(j) > {1'b0, idx});
    end
  end

  // Status
  always_comb begin
    st.any_act     = |act;
    st.slot_act    = act[idx];
    st.started     = started[idx];
    st.dly_done    = (el_add >= {1'b0, dly_i});
    st.eps_done    = eps_hit || time_up;
    st.div_last    = (dcnt == 4'd15);
    st.ease_lin    = (crv_i == ets_pkg::CRV_LINEAR) || (crv_i > ets_pkg::CRV_QUART_OUT);
    st.ease_smooth = (crv_i == ets_pkg::CRV_SMOOTH_END);
    st.ease_two    = (crv_i >= ets_pkg::CRV_CUBIC_IN) && (crv_i <= ets_pkg::CRV_QUART_OUT);
    st.int_bit     = sexp_i[{1'b1, ibit}];
    st.int_last    = (ibit == 3'd7);
    st.isq_last    = (bcnt == 5'd0);
    st.frac_bit    = sexp_i[{1'b0, k}];
    st.k_zero      = (k == 3'd0);
    st.slot_last   = ~|(act & above);
  end

  // Multiply into the product register
  always_ff @(posedge clk) begin
    mres <= ma * mb;
  end

  // Control state, current values and the epsilon register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) cur[i] <= '0;
      act     <= '0;
      started <= '0;
      valid   <= 1'b0;
      eps     <= ets_pkg::EPS_RESET;
    end else begin
      if (cfg_we) eps <= cfg_wdata;
      valid <= (cmd == ets_pkg::C_REPORT) || (cmd == ets_pkg::C_EMPTY) ||
               (cmd == ets_pkg::C_EMIT);
      case (cmd)
        ets_pkg::C_EXEC: begin
          case (op_r)
            ets_pkg::OP_START: begin
              act[idx]     <= 1'b1;
              started[idx] <= (dly_r == '0);
            end
            ets_pkg::OP_CANCEL: begin
              act[idx]     <= 1'b0;
              started[idx] <= 1'b0;
            end
            ets_pkg::OP_SET: cur[idx] <= value_r;
            ets_pkg::OP_CLEAR: begin
              act     <= '0;
              started <= '0;
            end
            default: ;
          endcase
        end
        ets_pkg::C_DLY: begin
          if (!started[idx] && st.dly_done) started[idx] <= 1'b1;
        end
        ets_pkg::C_EPS: begin
          if (st.eps_done) cur[idx] <= tgt_i;
        end
        ets_pkg::C_LST: cur[idx] <= snap ? tgt_i : lerp_v;
        ets_pkg::C_EMIT: begin
          if (fin) begin
            act[idx]     <= 1'b0;
            started[idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    case (cmd)
      ets_pkg::C_LATCH: begin
        op_r    <= opcode;
        idx     <= (opcode == ets_pkg::OP_TICK) ? '0 : slot;
        value_r <= value;
        dur_r   <= duration_us;
        dly_r   <= delay_us;
        frame_r <= frame_us;
        curve_r <= curve;
        sf_r    <= smooth_factor;
      end
      ets_pkg::C_EXEC: begin
        if (op_r == ets_pkg::OP_START) begin
          tgt[idx]    <= value_r;
          stv[idx]    <= cur_i;
          dur_a[idx]  <= dur_r;
          dly_a[idx]  <= dly_r;
          el_a[idx]   <= '0;
          crv_a[idx]  <= curve_r;
          sexp_a[idx] <= sf_r;
        end
      end
      ets_pkg::C_REPORT: begin
        out_slot     <= idx;
        out_value    <= cur_i;
        finished     <= 1'b0;
        active       <= act[idx];
        remaining_us <= rem_us;
        last         <= 1'b1;
      end
      ets_pkg::C_EMPTY: begin
        out_slot     <= '0;
        out_value    <= '0;
        finished     <= 1'b0;
        active       <= 1'b0;
        remaining_us <= '0;
        last         <= 1'b1;
      end
      ets_pkg::C_NEXT: idx <= idx + 1'b1;
      ets_pkg::C_DLY: begin
        fin <= 1'b0;
        if (started[idx]) begin
          el_a[idx] <= el_add;
        end else if (!st.dly_done) begin
          el_a[idx] <= el_add;
        end else begin
          stv[idx]  <= cur_i;
          el_a[idx] <= {1'b0, frame_r};
        end
      end
      ets_pkg::C_EPS: fin <= st.eps_done;
      ets_pkg::C_DIVI: begin
        rem  <= el_i[25:0];
        dcnt <= '0;
        p    <= '0;
      end
      ets_pkg::C_DIV: begin
        rem  <= dge ? 26'(r2 - {1'b0, dur_i}) : r2[25:0];
        p    <= {p[15:0], dge};
        dcnt <= dcnt + 1'b1;
      end
      ets_pkg::C_LIN: pe <= p;
      ets_pkg::C_EINIT: begin
        base <= ei_base;
        opb  <= ei_opb;
        sh17 <= ei_sh17;
        hi2  <= ei_hi2;
      end
      ets_pkg::C_PS1: t <= sh17 ? mres[33:17] : mres[32:16];
      ets_pkg::C_PS2: t <= mres[32:16];
      ets_pkg::C_EFIN: pe <= efin;
      ets_pkg::C_SINIT: begin
        acc  <= 31'h40000000;
        sq   <= {omp, 14'b0};
        s    <= {omp, 14'b0};
        ibit <= '0;
        k    <= 3'd7;
      end
      ets_pkg::C_SSA: acc <= mres[60:30];
      ets_pkg::C_SSQ: begin
        sq   <= mres[60:30];
        ibit <= ibit + 1'b1;
      end
      ets_pkg::C_QI: begin
        qx   <= {1'b0, s, 30'b0};
        qr   <= '0;
        bcnt <= 5'd30;
      end
      ets_pkg::C_QS: begin
        if (qge) begin
          qx <= qx - qsum;
          qr <= (qr >> 1) + qb;
        end else begin
          qr <= qr >> 1;
        end
        bcnt <= bcnt - 1'b1;
      end
      ets_pkg::C_QW: s <= qr[30:0];
      ets_pkg::C_FS: acc <= mres[60:30];
      ets_pkg::C_KDEC: k <= k - 1'b1;
      ets_pkg::C_SFIN: pe <= ets_pkg::P_ONE - acc[30:14];
      ets_pkg::C_LST: fin <= 1'b0;
      ets_pkg::C_EMIT: begin
        out_slot     <= idx;
        out_value    <= cur_i;
        finished     <= fin;
        active       <= 1'b1;
        remaining_us <= '0;
        last         <= st.slot_last;
        idx          <= idx + 1'b1;
      end
      default: ;
    endcase
  end

  // Only active slots report on a tick
  `ASSERT_IMPLIES(a_emit_active, clk, rst, cmd == ets_pkg::C_EMIT, act[idx])
  // Percent from the divider stays below one
  `ASSERT_IMPLIES(a_p_below_one, clk, rst, cmd == ets_pkg::C_LIN || cmd == ets_pkg::C_EINIT || cmd == ets_pkg::C_SINIT, p[16] == 1'b0)

endmodule

>>> hdl/easing_tween_slot_engine.sv
// Top level of the tween slot engine: sequencer plus datapath.
// Depends on ets_pkg, ets_ctrl, ets_dpath and assert_macros.svh.
//
// An item is taken when start is high and busy is low. Start, cancel, query,
// set, clear and the spare opcodes give one result after the EXEC and REPORT
// states. A tick walks the slots in order up to the last active one, skipping
// inactive slots, and gives one result per active slot (or a single empty
// result). A slot still in its delay goes from DLY straight to EMIT, and one
// that completes goes on through EPS to EMIT. Otherwise a slot runs the
// restoring divider that forms the percent, then the linear step, the
// multiply steps of the polynomial curves, or eight passes of the 31-step
// square-root unit on the smooth-end curve. Each result sits on the output
// ports for exactly one cycle with valid high and cannot be held off; the
// next item may be offered while the last result is shown.
`include "assert_macros.svh"

module easing_tween_slot_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          opcode,
  input  logic [ets_pkg::SLOT_W-1:0]          slot,
  input  logic signed [ets_pkg::VALUE_W-1:0]  value,
  input  logic [ets_pkg::TIME_W-1:0]          duration_us,
  input  logic [ets_pkg::TIME_W-1:0]          delay_us,
  input  logic [ets_pkg::TIME_W-1:0]          frame_us,
  input  logic [ets_pkg::CURVE_W-1:0]         curve,
  input  logic [ets_pkg::SF_W-1:0]            smooth_factor,
  input  logic                                cfg_we,
  input  logic [ets_pkg::EPS_W-1:0]           cfg_wdata,
  output logic                                valid,
  output logic [ets_pkg::SLOT_W-1:0]          out_slot,
  output logic signed [ets_pkg::VALUE_W-1:0]  out_value,
  output logic                                finished,
  output logic                                active,
  output logic [ets_pkg::EL_W-1:0]            remaining_us,
  output logic                                last
);

  ets_pkg::dp_cmd_t    cmd;
  ets_pkg::dp_status_t st;

  // Sequence items and slots
  ets_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold slot state and compute
  ets_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .opcode        (opcode),
    .slot          (slot),
    .value         (value),
    .duration_us   (duration_us),
    .delay_us      (delay_us),
    .frame_us      (frame_us),
    .curve         (curve),
    .smooth_factor (smooth_factor),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .valid         (valid),
    .out_slot      (out_slot),
    .out_value     (out_value),
    .finished      (finished),
    .active        (active),
    .remaining_us  (remaining_us),
    .last          (last)
  );

  // A result is shown only right after the engine was busy on an item
  `ASSERT_IMPLIES(a_valid_after_busy, clk, rst, valid, $past(busy))

endmodule

>>> tb/tb_easing_tween_slot_engine.sv
// Self-checking testbench of the tween slot engine: directed and random items.
// Depends on ets_pkg and the easing_tween_slot_engine RTL; an in-bench model
// predicts every result and a checker compares them as they appear.
module tb_easing_tween_slot_engine;
  import ets_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 10;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       value;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] frame;
    logic [CURVE_W-1:0] curve;
    logic [SF_W-1:0]   sf;
  } tween_item_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [31:0]       value;
    logic              fin;
    logic              act;
    logic [EL_W-1:0]   rem;
    logic              last;
  } slot_report_t;

  logic clk, rst, start, busy, cfg_we, valid, finished, active, last;
  logic [2:0] opcode;
  logic [SLOT_W-1:0] slot, out_slot;
  logic signed [VALUE_W-1:0] value, out_value;
  logic [TIME_W-1:0] duration_us, delay_us, frame_us;
  logic [CURVE_W-1:0] curve;
  logic [SF_W-1:0] smooth_factor;
  logic [EPS_W-1:0] cfg_wdata;
  logic [EL_W-1:0] remaining_us;

  // Model state of every slot
  logic [31:0]       cur_val [SLOTS];
  logic [31:0]       tgt_val [SLOTS];
  logic [31:0]       base_val[SLOTS];
  logic [TIME_W-1:0] dur_t   [SLOTS];
  logic [TIME_W-1:0] dly_t   [SLOTS];
  logic [EL_W-1:0]   el_t    [SLOTS];
  logic [CURVE_W-1:0] crv    [SLOTS];
  logic [SF_W-1:0]   sfac    [SLOTS];
  logic              run_f   [SLOTS];
  logic              act_f   [SLOTS];
  logic [EPS_W-1:0]  eps_floor;

  slot_report_t expected_reports[$];
  int mismatches;
  int idle_cycles;

  easing_tween_slot_engine u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .slot(slot), .value(value), .duration_us(duration_us), .delay_us(delay_us),
    .frame_us(frame_us), .curve(curve), .smooth_factor(smooth_factor),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .valid(valid), .out_slot(out_slot),
    .out_value(out_value), .finished(finished), .active(active),
    .remaining_us(remaining_us), .last(last)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Floor square root of a 64-bit value
  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Smooth end: 1 - (1-p)^f, f in Q8.8, worked in Q2.30
  function automatic logic [16:0] pow_smooth(input logic [16:0] p, input logic [15:0] f);
    logic [63:0] u, acc, sq, s;
    logic [7:0] n;
    u = 64'(P_ONE - p) << 14;
    acc = 64'h1 << 30;
    sq = u;
    s = u;
    n = f[15:8];
    while (n != 0) begin
      if (n[0]) acc = (acc * sq) >> 30;
      sq = (sq * sq) >> 30;
      n = n >> 1;
    end
    for (int k = 7; k >= 0; k--) begin
      s = isqrt(s << 30);
      if (f[k]) acc = (acc * s) >> 30;
    end
    return P_ONE - 17'(acc >> 14);
  endfunction

  function automatic logic [63:0] mul16(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 16;
  endfunction

  // Map a linear percent through the slot's curve
  function automatic logic [16:0] ease_pct(input logic [3:0] kind, input logic [16:0] p,
                                           input logic [15:0] f);
    logic [63:0] x, q, r;
    x = 64'(p);
    q = 64'(P_ONE - p);
    case (kind)
      CRV_SMOOTH_END: return pow_smooth(p, f);
      CRV_QUAD_INOUT: begin
        x = x << 1;
        if (x < 64'(P_ONE)) return 17'((x * x) >> 17);
        r = x - 64'(P_ONE);
        return 17'((64'(P_ONE) + mul16(r, 64'h20000 - r)) >> 1);
      end
      CRV_QUAD_IN:   return 17'(mul16(x, x));
      CRV_QUAD_OUT:  return 17'(mul16(x, 64'h20000 - x));
      CRV_CUBIC_IN:  return 17'(mul16(mul16(x, x), x));
      CRV_CUBIC_OUT: return P_ONE - 17'(mul16(mul16(q, q), q));
      CRV_QUART_IN: begin
        r = mul16(x, x);
        return 17'(mul16(r, r));
      end
      CRV_QUART_OUT: begin
        r = mul16(q, q);
        return P_ONE - 17'(mul16(r, r));
      end
      default: return p;
    endcase
  endfunction

  function automatic logic [31:0] interp(input logic [31:0] a, input logic [31:0] b,
                                         input logic [16:0] p);
    longint d;
    d = longint'($signed(b)) - longint'($signed(a));
    return 32'(longint'($signed(a)) + ((d * longint'(p)) >>> 16));
  endfunction

  function automatic longint int_part(input logic [31:0] v);
    longint x;
    x = longint'($signed(v));
    return (x >= 0) ? (x >>> 16) : -((-x) >>> 16);
  endfunction

  function automatic logic [EL_W-1:0] sat_sum(input logic [EL_W-1:0] a,
                                              input logic [TIME_W-1:0] b);
    logic [EL_W:0] t;
    t = {1'b0, a} + (EL_W+1)'(b);
    return t[EL_W] ? EL_MAX : t[EL_W-1:0];
  endfunction

  // Advance one active slot by a frame; return 1 when it completes
  function automatic logic advance_slot(input int s, input logic [TIME_W-1:0] frame);
    longint cur, tgt, diff, amax, thr;
    logic [16:0] p;
    logic [31:0] v;
    if (!run_f[s]) begin
      el_t[s] = sat_sum(el_t[s], frame);
      if (el_t[s] < EL_W'(dly_t[s])) return 1'b0;
      base_val[s] = cur_val[s];
      run_f[s] = 1'b1;
      el_t[s] = 0;
    end
    el_t[s] = sat_sum(el_t[s], frame);
    cur = longint'($signed(cur_val[s]));
    tgt = longint'($signed(tgt_val[s]));
    diff = (cur > tgt) ? cur - tgt : tgt - cur;
    amax = (cur < 0) ? -cur : cur;
    if (((tgt < 0) ? -tgt : tgt) > amax) amax = (tgt < 0) ? -tgt : tgt;
    thr = amax >>> 20;
    if (longint'(eps_floor) > thr) thr = longint'(eps_floor);
    if (diff <= thr) begin
      cur_val[s] = tgt_val[s];
      return 1'b1;
    end
    if (el_t[s] >= EL_W'(dur_t[s])) p = P_ONE;
    else p = 17'((64'(el_t[s]) << 16) / 64'(dur_t[s]));
    if (p >= P_ONE) begin
      cur_val[s] = tgt_val[s];
      return 1'b1;
    end
    p = ease_pct(crv[s], p, sfac[s]);
    if (crv[s] == CRV_SMOOTH_END) begin
      v = interp(base_val[s], tgt_val[s], p);
      if (int_part(v) == int_part(tgt_val[s])) p = P_ONE;
    end
    cur_val[s] = interp(base_val[s], tgt_val[s], p);
    return 1'b0;
  endfunction

  function automatic logic [EL_W-1:0] remaining_time(input int s);
    logic [31:0] rem;
    rem = 0;
    if (!act_f[s]) return 0;
    if (!run_f[s]) begin
      if (EL_W'(dly_t[s]) > el_t[s]) rem = 32'(dly_t[s]) - 32'(el_t[s]);
      rem = rem + 32'(dur_t[s]);
      return rem[EL_W-1:0];
    end
    return (EL_W'(dur_t[s]) > el_t[s]) ? EL_W'(dur_t[s]) - el_t[s] : 0;
  endfunction

  // Apply one accepted item to the model and queue the reports it causes
  function automatic void model_apply(input tween_item_t it);
    slot_report_t r;
    int lastk;
    int s;
    lastk = -1;
    s = int'(it.slot);
    if (it.op == OP_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (act_f[i]) begin
          r.fin = advance_slot(i, it.frame);
          if (r.fin) begin
            act_f[i] = 1'b0;
            run_f[i] = 1'b0;
          end
          r.slot = SLOT_W'(i);
          r.value = cur_val[i];
          r.act = 1'b1;
          r.rem = 0;
          r.last = 1'b0;
          expected_reports.push_back(r);
          lastk = expected_reports.size() - 1;
        end
      end
      if (lastk < 0) begin
        r = '{slot: 0, value: 0, fin: 0, act: 0, rem: 0, last: 1};
        expected_reports.push_back(r);
      end else begin
        expected_reports[lastk].last = 1'b1;
      end
      return;
    end
    if (it.op == OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) begin
        act_f[i] = 1'b0;
        run_f[i] = 1'b0;
      end
    end
    case (it.op)
      OP_START: begin
        tgt_val[s] = it.value;
        base_val[s] = cur_val[s];
        dur_t[s] = it.dur;
        dly_t[s] = it.dly;
        el_t[s] = 0;
        crv[s] = it.curve;
        sfac[s] = it.sf;
        run_f[s] = (it.dly == 0);
        act_f[s] = 1'b1;
      end
      OP_CANCEL: begin
        act_f[s] = 1'b0;
        run_f[s] = 1'b0;
      end
      OP_SET: cur_val[s] = it.value;
      default: ;
    endcase
    r = '{slot: it.slot, value: cur_val[s], fin: 0, act: act_f[s],
          rem: remaining_time(s), last: 1};
    expected_reports.push_back(r);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input tween_item_t it);
    int gap;
    gap = $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode <= it.op;
    slot <= it.slot;
    value <= it.value;
    duration_us <= it.dur;
    delay_us <= it.dly;
    frame_us <= it.frame;
    curve <= it.curve;
    smooth_factor <= it.sf;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    model_apply(it);
  endtask

  // Hold off the sender until every queued report has arrived
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    eps_floor = v;
  endtask

  function automatic tween_item_t mk(input logic [2:0] op, input int sl, input logic [31:0] v,
                                     input int dur, input int dly, input int frame,
                                     input int cv, input int sf);
    tween_item_t it;
    it = '{op: op, slot: SLOT_W'(sl), value: v, dur: TIME_W'(dur), dly: TIME_W'(dly),
           frame: TIME_W'(frame), curve: CURVE_W'(cv), sf: SF_W'(sf)};
    return it;
  endfunction

  function automatic tween_item_t random_item();
    tween_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.slot = SLOT_W'($urandom_range(0, 15));
    it.value = ($urandom_range(0, 3) == 0) ? $urandom() :
               32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    it.dur = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom()) :
             TIME_W'($urandom_range(0, 20000));
    it.dly = ($urandom_range(0, 1) == 0) ? 0 :
             (($urandom_range(0, 9) == 0) ? TIME_W'($urandom()) :
              TIME_W'($urandom_range(1, 8000)));
    it.frame = ($urandom_range(0, 11) == 0) ? TIME_W'($urandom()) :
               TIME_W'($urandom_range(0, 4000));
    it.curve = ($urandom_range(0, 7) == 0) ? CURVE_W'($urandom_range(9, 15)) :
               CURVE_W'($urandom_range(0, 8));
    it.sf = SF_W'($urandom());
    if (pick < 40) it.op = OP_TICK;
    else if (pick < 70) it.op = OP_START;
    else if (pick < 78) it.op = OP_SET;
    else if (pick < 86) it.op = OP_QUERY;
    else if (pick < 93) it.op = OP_CANCEL;
    else if (pick < 96) it.op = OP_CLEAR;
    else it.op = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
    return it;
  endfunction

  // Exercise query, tick, set and the spare opcodes, the value extremes and an empty tick
  task automatic test_opcodes();
    send_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_SET, 1, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
    send_item(mk(OP_SET, 2, 32'h80000000, 0, 0, 0, 0, 0));
    send_item(mk(OP_SPARE6, 3, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    send_item(mk(OP_SPARE7, 15, 0, 0, 0, 0, 0, 0));
  endtask

  // Start every curve, an unknown curve code, a delayed and a zero-length one, then tick them out
  task automatic test_curves();
    for (int c = 0; c <= 8; c++)
      send_item(mk(OP_START, c, 32'(c * 3 + 1) << 16, 1000, 0, 0, c, 16'h0180));
    send_item(mk(OP_START, 9, 32'hFFF00000, 1000, 0, 0, 15, 0));
    send_item(mk(OP_START, 10, 32'h00500000, 2000, 3000, 0, 0, 0));
    send_item(mk(OP_START, 11, 32'h00100000, 0, 0, 0, 0, 0));
    send_item(mk(OP_TICK, 0, 0, 0, 0, 400, 0, 0));
    send_item(mk(OP_TICK, 0, 0, 0, 0, 400, 0, 0));
    send_item(mk(OP_QUERY, 10, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_CANCEL, 3, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_TICK, 0, 0, 0, 0, 26'h3FFFFFF, 0, 0));
    send_item(mk(OP_START, 12, 0, 26'h3FFFFFF, 26'h3FFFFFF, 0, 1, 16'hFFFF));
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Random items under one epsilon setting; the calls include the extremes
  task automatic test_random(input logic [EPS_W-1:0] eps, input int count);
    write_epsilon(eps);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // Compare each report with the oldest prediction
  always @(posedge clk) begin
    slot_report_t e;
    if (!rst && valid) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected report: slot %0d value %h", out_slot, out_value);
      end else begin
        e = expected_reports.pop_front();
        if (out_slot !== e.slot || out_value !== e.value || finished !== e.fin ||
            active !== e.act || remaining_us !== e.rem || last !== e.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp slot %0d val %h fin %b act %b rem %0d last %b / got slot %0d val %h fin %b act %b rem %0d last %b",
                     e.slot, e.value, e.fin, e.act, e.rem, e.last,
                     out_slot, out_value, finished, active, remaining_us, last);
        end
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 0;
    opcode = OP_TICK;
    slot = 0;
    value = 0;
    duration_us = 0;
    delay_us = 0;
    frame_us = 0;
    curve = CRV_LINEAR;
    smooth_factor = 0;
    eps_floor = EPS_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      cur_val[i] = 0; tgt_val[i] = 0; base_val[i] = 0; dur_t[i] = 0; dly_t[i] = 0;
      el_t[i] = 0; crv[i] = 0; sfac[i] = 0; run_f[i] = 0; act_f[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_opcodes();
    test_curves();
    test_random(16'd0, 50);
    test_random(16'hFFFF, 45);
    test_random(16'(EPS_RESET), 55);
    test_random(16'($urandom()), 50);

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
